// ===== rtl/i2c_master_bit_engine_assert.svh =====
// assertion macros for the i2c master bit engine checker
// expects clk_i and rst_ni to be visible where a macro is used
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// condition in a cycle implies a consequence in the same cycle
`define I2CM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition in a cycle implies a consequence in the next cycle
`define I2CM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/i2cm_pkg.sv =====
// shared types and codes for the i2c master bit engine
// used by the top level, its checker and the testbench, no dependencies
package i2cm_pkg;

  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_START   = 3'd1;
  localparam logic [2:0] FUNC_STOP    = 3'd2;
  localparam logic [2:0] FUNC_WRITE   = 3'd3;
  localparam logic [2:0] FUNC_READ    = 3'd4;
  localparam logic [2:0] FUNC_ADDR_WR = 3'd5;
  localparam logic [2:0] FUNC_ADDR_RD = 3'd6;

  localparam logic [15:0] HALF_BIT_RESET = 16'd5;
  localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       nack_req;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       cmd_done;
    logic       ack_ok;
    logic [7:0] rx_byte;
    logic       status;
  } out_item_t;

endpackage

// ===== rtl/i2c_master_bit_engine.sv =====
// i2c master bit engine top level
// depends on i2cm_pkg
//
// Takes one item per clock while the output does not stall and returns one result
// item per input item: the item is captured in an input register, then the bus
// sequencer (a small phase/bit/tick counter set) updates its state and loads the
// result register. Tick items advance the half-bit counter; a half_bit_ticks of
// zero counts as one. Commands accepted while a command is still running are
// rejected with status set. Output stall backs up through both registers to the
// input stall. Configuration writes are always ready; the user is to make them
// only while the block is idle, which the block itself does not enforce.
module i2c_master_bit_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  i2cm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output i2cm_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import i2cm_pkg::*;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_START,
    OP_STOP,
    OP_WRITE,
    OP_READ
  } op_e;

  op_e        op_q, op_d;
  logic [1:0] phase_q, phase_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [15:0] tick_q, tick_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       nack_q, nack_d;
  logic       ack_q, ack_d;
  logic [15:0] hb_q;

  in_item_t   in_q;
  logic       in_vld_q;
  out_item_t  out_q, res_d;
  logic       out_vld_q;
  logic       adv;

  assign adv         = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !adv;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [16:0] tick_inc;
    logic [15:0] hb;
    logic [7:0]  sh_nx;
    logic [3:0]  bi_nx;
    logic        fin;
    op_d     = op_q;
    phase_d  = phase_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    tick_d   = tick_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    nack_d   = nack_q;
    ack_d    = ack_q;
    res_d    = '0;
    fin      = 1'b0;
    hb       = (hb_q == 16'd0) ? 16'd1 : hb_q;
    tick_inc = {1'b0, tick_q} + 17'd1;
    bi_nx    = bit_q + 4'd1;
    sh_nx    = {shift_q[6:0], (op_q == OP_READ) ? in_q.sda_in : 1'b0};

    if (in_q.func == FUNC_TICK) begin
      if (op_q != OP_IDLE) begin
        if (tick_inc >= {1'b0, hb}) begin
          tick_d = '0;
          unique case (op_q)
            OP_START: begin
              if (phase_q == 2'd0) begin
                sda_d = 1'b0; phase_d = 2'd1;
              end else if (phase_q == 2'd1) begin
                scl_d = 1'b0; phase_d = 2'd2;
              end else begin
                fin = 1'b1;
              end
            end
            OP_STOP: begin
              if (phase_q == 2'd0) begin
                scl_d = 1'b1; phase_d = 2'd1;
              end else if (phase_q == 2'd1) begin
                sda_d = 1'b1; phase_d = 2'd2;
              end else begin
                fin = 1'b1;
              end
            end
            OP_WRITE, OP_READ: begin
              if (phase_q == 2'd0) begin
                scl_d = 1'b1; phase_d = 2'd1;
              end else if (phase_q == 2'd1) begin
                scl_d = 1'b0;
                if (bit_q < BITS_PER_BYTE) begin
                  shift_d = sh_nx;
                  bit_d   = bi_nx;
                  phase_d = 2'd0;
                  if (bi_nx < BITS_PER_BYTE) begin
                    sda_d = (op_q == OP_WRITE) ? sh_nx[7] : 1'b1;
                  end else begin
                    sda_d = (op_q == OP_WRITE) ? 1'b1 : nack_q;
                  end
                end else begin
                  // ack slot high half ends here
                  if (op_q == OP_WRITE) ack_d = !in_q.sda_in;
                  phase_d = 2'd2;
                end
              end else begin
                scl_d = 1'b0;
                sda_d = 1'b1;
                fin   = 1'b1;
              end
            end
            default: ;
          endcase
          if (fin) begin
            res_d.cmd_done = 1'b1;
            if (op_q == OP_WRITE) res_d.ack_ok = ack_q;
            if (op_q == OP_READ) res_d.rx_byte = shift_q;
            op_d    = OP_IDLE;
            phase_d = 2'd0;
            bit_d   = 4'd0;
          end
        end else begin
          tick_d = tick_inc[15:0];
        end
      end
    end else if (in_q.func <= FUNC_ADDR_RD) begin
      if (op_q != OP_IDLE) begin
        res_d.status = 1'b1;
      end else begin
        phase_d = 2'd0;
        bit_d   = 4'd0;
        tick_d  = '0;
        ack_d   = 1'b0;
        unique case (in_q.func)
          FUNC_START: begin
            op_d = OP_START; scl_d = 1'b1; sda_d = 1'b1;
          end
          FUNC_STOP: begin
            op_d = OP_STOP; scl_d = 1'b0; sda_d = 1'b0;
          end
          FUNC_READ: begin
            op_d = OP_READ; nack_d = in_q.nack_req; shift_d = '0;
            scl_d = 1'b0; sda_d = 1'b1;
          end
          default: begin
            op_d = OP_WRITE;
            // address commands drop tx bit 7 and append the r/w bit
            if (in_q.func == FUNC_WRITE) shift_d = in_q.tx_byte;
            else shift_d = {in_q.tx_byte[6:0], in_q.func == FUNC_ADDR_RD};
            scl_d = 1'b0;
            sda_d = shift_d[7];
          end
        endcase
      end
    end
    res_d.scl_level = scl_d;
    res_d.sda_level = sda_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= OP_IDLE;
      phase_q   <= 2'd0;
      bit_q     <= 4'd0;
      shift_q   <= 8'd0;
      tick_q    <= 16'd0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      nack_q    <= 1'b0;
      ack_q     <= 1'b0;
      hb_q      <= HALF_BIT_RESET;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      in_q      <= '0;
      out_q     <= '0;
    end else begin
      if (cfg_valid_i) hb_q <= cfg_data_i;
      if (in_valid_i && !in_stall_o) begin
        in_q <= in_item_i;
      end
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (adv) begin
        op_q    <= op_d;
        phase_q <= phase_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        tick_q  <= tick_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        nack_q  <= nack_d;
        ack_q   <= ack_d;
        out_q   <= res_d;
      end
      if (adv) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

endmodule

// ===== rtl/i2cm_checker.sv =====
// port-level checker for the i2c master bit engine, bound to the top level
// depends on i2cm_pkg and i2c_master_bit_engine_assert.svh
`include "i2c_master_bit_engine_assert.svh"

module i2cm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input i2cm_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input i2cm_pkg::out_item_t out_item_o
);
  import i2cm_pkg::*;

  out_item_t res;
  assign res = out_item_o;

  // a rejected command never completes anything
  `I2CM_ASSERT_SAME(a_reject_not_done, out_valid_o && res.status, !res.cmd_done)
  // ack and received data only show with a completion
  `I2CM_ASSERT_SAME(a_ack_with_done, out_valid_o && res.ack_ok, res.cmd_done)
  `I2CM_ASSERT_SAME(a_rx_with_done, out_valid_o && (res.rx_byte != 8'd0), res.cmd_done)
  // a stalled item holds on either side
  `I2CM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  `I2CM_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_item_i))

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);

// ===== dv/i2c_master_bit_engine_tb.sv =====
// testbench for the i2c master bit engine: directed and random item streams
// checked against a cycle-free bus sequencer model, depends on i2cm_pkg and i2c_master_bit_engine
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;
  import i2cm_pkg::*;

  localparam logic [2:0] FUNC_NOP = 3'd7;
  localparam int SDA_LOW = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int REPORT_MAX = 10;

  typedef enum logic [2:0] {BUS_IDLE, BUS_START, BUS_STOP, BUS_WRITE, BUS_READ} bus_op_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_item_t   in_item_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [15:0] cfg_data_i;

  i2c_master_bit_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // sequencer state as the block should hold it
  logic [15:0] half_bit = HALF_BIT_RESET;
  bus_op_e     cur_op = BUS_IDLE;
  logic [2:0]  seg_phase = '0;
  logic [3:0]  bits_done = '0;
  logic [7:0]  shifter = '0;
  logic [15:0] tick_cnt = '0;
  logic        scl_q = 1'b1;
  logic        sda_q = 1'b1;
  logic        nack_q = 1'b0;
  logic        ack_q = 1'b0;

  out_item_t   expected_bus[$];
  out_item_t   bus_want;
  int          live_items = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  function automatic out_item_t predict_bus(input in_item_t it);
    out_item_t   r;
    logic [15:0] hb;
    logic        fin;
    r = '0;
    fin = 1'b0;
    if (it.func == FUNC_TICK) begin
      if (cur_op != BUS_IDLE) begin
        live_items++;
        hb = (half_bit == 16'd0) ? 16'd1 : half_bit;
        tick_cnt++;
        if (tick_cnt >= hb) begin
          tick_cnt = '0;
          case (cur_op)
            BUS_START: begin
              if (seg_phase == 3'd0) begin
                sda_q = 1'b0;
                seg_phase = 3'd1;
              end else if (seg_phase == 3'd1) begin
                scl_q = 1'b0;
                seg_phase = 3'd2;
              end else begin
                fin = 1'b1;
              end
            end
            BUS_STOP: begin
              if (seg_phase == 3'd0) begin
                scl_q = 1'b1;
                seg_phase = 3'd1;
              end else if (seg_phase == 3'd1) begin
                sda_q = 1'b1;
                seg_phase = 3'd2;
              end else begin
                fin = 1'b1;
              end
            end
            BUS_WRITE, BUS_READ: begin
              if (seg_phase == 3'd0) begin
                scl_q = 1'b1;
                seg_phase = 3'd1;
              end else if (seg_phase == 3'd1) begin
                if (bits_done < BITS_PER_BYTE) begin
                  shifter = {shifter[6:0], (cur_op == BUS_READ) ? it.sda_in : 1'b0};
                  bits_done++;
                  scl_q = 1'b0;
                  if (bits_done < BITS_PER_BYTE) begin
                    sda_q = (cur_op == BUS_WRITE) ? shifter[7] : 1'b1;
                  end else begin
                    // ack slot: write releases the line, read drives ack or nack
                    sda_q = (cur_op == BUS_WRITE) ? 1'b1 : nack_q;
                  end
                  seg_phase = 3'd0;
                end else begin
                  if (cur_op == BUS_WRITE) ack_q = !it.sda_in;
                  scl_q = 1'b0;
                  seg_phase = 3'd2;
                end
              end else begin
                scl_q = 1'b0;
                sda_q = 1'b1;
                fin = 1'b1;
              end
            end
            default: ;
          endcase
          if (fin) begin
            r.cmd_done = 1'b1;
            if (cur_op == BUS_WRITE) r.ack_ok = ack_q;
            if (cur_op == BUS_READ) r.rx_byte = shifter;
            cur_op = BUS_IDLE;
            seg_phase = '0;
            bits_done = '0;
          end
        end
      end
    end else if (it.func != FUNC_NOP) begin
      if (cur_op != BUS_IDLE) begin
        r.status = 1'b1;
      end else begin
        live_items++;
        seg_phase = '0;
        bits_done = '0;
        tick_cnt = '0;
        ack_q = 1'b0;
        case (it.func)
          FUNC_START: begin
            cur_op = BUS_START;
            scl_q = 1'b1;
            sda_q = 1'b1;
          end
          FUNC_STOP: begin
            cur_op = BUS_STOP;
            scl_q = 1'b0;
            sda_q = 1'b0;
          end
          FUNC_READ: begin
            cur_op = BUS_READ;
            nack_q = it.nack_req;
            shifter = '0;
            scl_q = 1'b0;
            sda_q = 1'b1;
          end
          default: begin
            cur_op = BUS_WRITE;
            if (it.func == FUNC_WRITE) shifter = it.tx_byte;
            else if (it.func == FUNC_ADDR_WR) shifter = {it.tx_byte[6:0], 1'b0};
            else shifter = {it.tx_byte[6:0], 1'b1};
            scl_q = 1'b0;
            sda_q = shifter[7];
          end
        endcase
      end
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    return r;
  endfunction

  function automatic in_item_t rand_item(input logic [2:0] f);
    in_item_t it;
    it.func = f;
    it.tx_byte = 8'($urandom_range(255));
    it.nack_req = 1'($urandom_range(1));
    it.sda_in = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic string fmt_item(input out_item_t r);
    return $sformatf("scl %b sda %b done %b ack %b rx %h status %b", r.scl_level,
                     r.sda_level, r.cmd_done, r.ack_ok, r.rx_byte, r.status);
  endfunction

  // valid stays high after the handshake, the next call lowers it only for idle gaps, a drain lowers it
  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i = it;
    do @(posedge clk_i); while (in_stall_o);
    expected_bus.push_back(predict_bus(it));
  endtask

  // ticks until the running command completes, with stray commands mixed in
  task automatic finish_command(input int sda_mode, input int noise_pct);
    in_item_t it;
    while (cur_op != BUS_IDLE) begin
      it = rand_item(FUNC_TICK);
      if (sda_mode == SDA_LOW) it.sda_in = 1'b0;
      else if (sda_mode == SDA_HIGH) it.sda_in = 1'b1;
      if ($urandom_range(99) < noise_pct) it.func = 3'($urandom_range(FUNC_START, FUNC_NOP));
      send_item(it);
    end
  endtask

  task automatic run_command(input logic [2:0] f, input logic [7:0] tx, input logic nack,
                             input int sda_mode);
    in_item_t it;
    it = rand_item(f);
    it.tx_byte = tx;
    it.nack_req = nack;
    send_item(it);
    finish_command(sda_mode, 0);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_bus.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_half_bit(input logic [15:0] v);
    finish_command(SDA_RAND, 0);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_data_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    half_bit = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // runs at the reset half-bit length
  task automatic test_start_stop();
    run_command(FUNC_START, 8'h00, 1'b0, SDA_RAND);
    run_command(FUNC_STOP, 8'hFF, 1'b1, SDA_RAND);
  endtask

  task automatic test_write_byte();
    set_half_bit(16'd1);
    run_command(FUNC_WRITE, 8'hFF, 1'b0, SDA_LOW);
    run_command(FUNC_WRITE, 8'h00, 1'b1, SDA_HIGH);
    run_command(FUNC_WRITE, 8'hA5, 1'b0, SDA_RAND);
  endtask

  task automatic test_read_byte();
    run_command(FUNC_READ, 8'h00, 1'b1, SDA_HIGH);
    run_command(FUNC_READ, 8'hFF, 1'b0, SDA_LOW);
    run_command(FUNC_READ, 8'h5A, 1'b1, SDA_RAND);
  endtask

  // address bit seven must fall off in the shift
  task automatic test_address();
    run_command(FUNC_ADDR_WR, 8'hFF, 1'b0, SDA_LOW);
    run_command(FUNC_ADDR_RD, 8'h80, 1'b1, SDA_HIGH);
    run_command(FUNC_ADDR_RD, 8'h7F, 1'b0, SDA_RAND);
  endtask

  task automatic test_busy_and_nop();
    send_item(rand_item(FUNC_TICK));
    send_item(rand_item(FUNC_NOP));
    send_item(rand_item(FUNC_WRITE));
    for (int f = FUNC_START; f <= FUNC_NOP; f++) begin
      send_item(rand_item(FUNC_TICK));
      send_item(rand_item(3'(f)));
    end
    finish_command(SDA_RAND, 0);
  endtask

  task automatic test_half_bit_settings();
    set_half_bit(16'd0);
    run_command(FUNC_WRITE, 8'($urandom_range(255)), 1'b0, SDA_RAND);
    set_half_bit(16'd2);
    run_command(FUNC_READ, 8'h00, 1'($urandom_range(1)), SDA_RAND);
    set_half_bit(16'd3);
    run_command(FUNC_START, 8'h00, 1'b0, SDA_RAND);
  endtask

  // mostly complete commands with random content, the rest loose items
  task automatic test_random(input int target, input logic [15:0] hb);
    int first;
    int n;
    set_half_bit(hb);
    first = live_items;
    while (live_items - first < target) begin
      if ($urandom_range(99) < 80) begin
        finish_command(SDA_RAND, 10);
        send_item(rand_item(3'($urandom_range(FUNC_START, FUNC_ADDR_RD))));
        finish_command(SDA_RAND, 5);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(rand_item(3'($urandom_range(FUNC_TICK, FUNC_NOP))));
      end
    end
  endtask

  // start holds both lines high through the first part of a maximum half bit
  task automatic test_longest_half_bit();
    set_half_bit(16'hFFFF);
    send_item(rand_item(FUNC_START));
    repeat (40) send_item(rand_item(FUNC_TICK));
  endtask

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bus.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result with nothing expected: %s", fmt_item(out_item_o));
      end else begin
        bus_want = expected_bus.pop_front();
        if (out_item_o.scl_level !== bus_want.scl_level ||
            out_item_o.sda_level !== bus_want.sda_level ||
            out_item_o.cmd_done !== bus_want.cmd_done ||
            out_item_o.ack_ok !== bus_want.ack_ok ||
            out_item_o.rx_byte !== bus_want.rx_byte ||
            out_item_o.status !== bus_want.status) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch at cycle %0d: expected %s, got %s", cycles,
                     fmt_item(bus_want), fmt_item(out_item_o));
        end
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 25;
    stall_pct = 75;
    test_start_stop();
    test_write_byte();
    test_read_byte();
    test_address();
    test_busy_and_nop();
    test_half_bit_settings();
    test_random(140, 16'd1);

    send_idle_pct = 75;
    stall_pct = 25;
    test_random(140, 16'($urandom_range(1, 3)));

    send_idle_pct = 0;
    stall_pct = 0;
    test_random(140, 16'd1);
    test_longest_half_bit();

    wait_drained();
    if (mismatches == 0 && expected_bus.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
